// ----- rtl/core/bthd_pkg.sv -----
// Shared types and constants for the button tap/hold detector.
`timescale 1ns / 1ps

package bthd_pkg;

    localparam int BTN_W   = 8;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DTAP_WIN   = 2'd2;

    localparam logic [CFG_W-1:0] MIN_PRESS_RST = 16'd2;
    localparam logic [CFG_W-1:0] MIN_HOLD_RST  = 16'd60;
    localparam logic [CFG_W-1:0] DTAP_WIN_RST  = 16'd30;

    typedef struct packed {
        logic [CFG_W-1:0] min_press_ticks;
        logic [CFG_W-1:0] min_hold_ticks;
        logic [CFG_W-1:0] double_tap_window;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] hold_count;
        logic [BTN_W-1:0]   held_mask;
        logic [BTN_W-1:0]   double_tap_mask;
        logic [BTN_W-1:0]   released_mask;
    } result_t;

endpackage

// ----- rtl/core/bthd_core.sv -----
// Detector state registers and the per-tick update logic.
`timescale 1ns / 1ps

module bthd_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic [bthd_pkg::BTN_W-1:0]          now_buttons,
    input  bthd_pkg::cfg_t                      cfg,
    output bthd_pkg::result_t                   result
);

    logic [bthd_pkg::BTN_W-1:0]   prev_reg, prev_next;
    logic [bthd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [bthd_pkg::BTN_W-1:0]   held_reg, held_next;
    logic [bthd_pkg::BTN_W-1:0]   last_rel_reg, last_rel_next;
    logic [bthd_pkg::BTN_W-1:0]   hist_reg, hist_next;

    logic [bthd_pkg::COUNT_W-1:0] count_inc;
    logic [bthd_pkg::BTN_W-1:0]   gone;
    logic [bthd_pkg::BTN_W-1:0]   tapped;
    logic [bthd_pkg::BTN_W-1:0]   twice;

    always_comb begin
        hist_next     = hist_reg;
        prev_next     = prev_reg;
        count_next    = count_reg;
        held_next     = held_reg;
        tapped        = '0;
        twice         = '0;
        count_inc     = (count_reg == bthd_pkg::COUNT_MAX) ? count_reg
                                                           : count_reg + 1'b1;
        gone          = prev_reg & ~now_buttons;

        if (last_rel_reg != '0) begin
            hist_next = last_rel_reg;
        end else if (count_reg > cfg.double_tap_window) begin
            hist_next = '0;
        end

        if (now_buttons == prev_reg) begin
            count_next = count_inc;
            held_next  = (count_inc > cfg.min_hold_ticks) ? now_buttons : '0;
        end else begin
            prev_next = now_buttons;
            if ((gone & held_reg) == '0) begin
                count_next = '0;
                if (count_reg < cfg.min_hold_ticks && count_reg > cfg.min_press_ticks) begin
                    tapped = gone;
                    twice  = gone & hist_next;
                end
            end
        end
        last_rel_next = tapped;

        result.released_mask   = tapped;
        result.double_tap_mask = twice;
        result.held_mask       = held_next;
        result.hold_count      = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            count_reg    <= '0;
            held_reg     <= '0;
            last_rel_reg <= '0;
            hist_reg     <= '0;
        end else if (step) begin
            prev_reg     <= prev_next;
            count_reg    <= count_next;
            held_reg     <= held_next;
            last_rel_reg <= last_rel_next;
            hist_reg     <= hist_next;
        end
    end

endmodule

// ----- rtl/core/button_tap_hold_detector.sv -----
// Top level of the button tap, double-tap and long-press detector.
// Usage:
//   Each request on the s_axis channel is one tick: raw pins and a software
//   mask, ORed together. Every tick gives exactly one result on m_axis: the
//   tap mask, the double-tap mask, the held mask and the unchanged-tick count.
//   Thresholds are written through cfg_wr_en / cfg_index / cfg_data while
//   the block is idle; index 0 min press, 1 min hold, 2 double-tap window.
// Timing:
//   A request is registered at the input, updated combinationally against the
//   detector state, and lands in the result register that drives
//   m_axis_tvalid. One request per cycle is sustained while m_axis_tready
//   stays high; the state update loop, stepped on each advance, sets that rate.
// Reset:
//   aresetn (synchronous, active low) clears the detector state, empties both
//   registers and restores the threshold defaults 2, 60 and 30.
// Stall:
//   While m_axis_tready is low the result holds, one more request is taken
//   into the input register, and then s_axis_tready drops until the
//   result is taken.
`timescale 1ns / 1ps

module button_tap_hold_detector #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] raw_buttons, [15:8] soft_buttons
    input  logic [15:0]                        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] released_mask, [15:8] double_tap_mask, [23:16] held_mask,
    // [39:24] hold_count
    output logic [39:0]                        m_axis_tdata,
    input  logic                               cfg_wr_en,
    input  logic [bthd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bthd_pkg::CFG_W-1:0]         cfg_data
);

    localparam logic [bthd_pkg::BTN_W-1:0] BTN_MASK =
        (NUM_BUTTONS >= bthd_pkg::BTN_W) ? {bthd_pkg::BTN_W{1'b1}}
                                         : bthd_pkg::BTN_W'((1 << NUM_BUTTONS) - 1);

    bthd_pkg::cfg_t                 cfg_reg;
    logic                           in_valid_reg;
    logic [bthd_pkg::BTN_W-1:0]     now_reg;
    logic                           out_valid_reg;
    bthd_pkg::result_t              out_reg;
    bthd_pkg::result_t              result;
    logic                           advance;
    logic                           in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_press_ticks   <= bthd_pkg::MIN_PRESS_RST;
            cfg_reg.min_hold_ticks    <= bthd_pkg::MIN_HOLD_RST;
            cfg_reg.double_tap_window <= bthd_pkg::DTAP_WIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bthd_pkg::REG_MIN_PRESS: cfg_reg.min_press_ticks   <= cfg_data;
                bthd_pkg::REG_MIN_HOLD:  cfg_reg.min_hold_ticks    <= cfg_data;
                bthd_pkg::REG_DTAP_WIN:  cfg_reg.double_tap_window <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            now_reg <= (s_axis_tdata[7:0] | s_axis_tdata[15:8]) & BTN_MASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    bthd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .now_buttons (now_reg),
        .cfg         (cfg_reg),
        .result      (result)
    );

endmodule

// ----- tb/button_tap_hold_detector_tb.sv -----
// Self-checking testbench for button_tap_hold_detector: directed and random ticks vs. a predictor.
`timescale 1ns / 1ps

module button_tap_hold_detector_tb;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int PHASE_TICKS     = 140;
    localparam int HELD_TICKS      = 70;

    class tap_hold_tracker;
        bthd_pkg::cfg_t                 thresholds;
        logic [bthd_pkg::BTN_W-1:0]     prev_mask;
        logic [bthd_pkg::BTN_W-1:0]     held;
        logic [bthd_pkg::BTN_W-1:0]     last_tap;
        logic [bthd_pkg::BTN_W-1:0]     tap_history;
        logic [bthd_pkg::COUNT_W-1:0]   tick_cnt;
        bthd_pkg::result_t              awaited[$];
        int                             errors;

        function new();
            thresholds.min_press_ticks   = bthd_pkg::MIN_PRESS_RST;
            thresholds.min_hold_ticks    = bthd_pkg::MIN_HOLD_RST;
            thresholds.double_tap_window = bthd_pkg::DTAP_WIN_RST;
            prev_mask   = '0;
            held        = '0;
            last_tap    = '0;
            tap_history = '0;
            tick_cnt    = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [bthd_pkg::CFG_IDX_W-1:0] idx,
                              logic [bthd_pkg::CFG_W-1:0] value);
            case (idx)
                bthd_pkg::REG_MIN_PRESS: thresholds.min_press_ticks   = value;
                bthd_pkg::REG_MIN_HOLD:  thresholds.min_hold_ticks    = value;
                bthd_pkg::REG_DTAP_WIN:  thresholds.double_tap_window = value;
                default: ;
            endcase
        endfunction

        function void note_tick(logic [bthd_pkg::BTN_W-1:0] raw,
                                logic [bthd_pkg::BTN_W-1:0] sw_mask);
            logic [bthd_pkg::BTN_W-1:0]   now_mask;
            logic [bthd_pkg::BTN_W-1:0]   gone;
            logic [bthd_pkg::COUNT_W-1:0] cnt;
            bthd_pkg::result_t            r;
            now_mask = raw | sw_mask;
            cnt      = tick_cnt;
            r        = '0;
            if (last_tap != '0) begin
                tap_history = last_tap;
            end else if (cnt > thresholds.double_tap_window) begin
                tap_history = '0;
            end
            if (now_mask == prev_mask) begin
                if (cnt != bthd_pkg::COUNT_MAX) begin
                    cnt = cnt + 1'b1;
                end
                held     = (cnt > thresholds.min_hold_ticks) ? now_mask : '0;
                tick_cnt = cnt;
            end else begin
                gone      = prev_mask & ~now_mask;
                prev_mask = now_mask;
                if ((gone & held) == '0) begin
                    tick_cnt = '0;
                    if (cnt < thresholds.min_hold_ticks && cnt > thresholds.min_press_ticks) begin
                        r.released_mask   = gone;
                        r.double_tap_mask = gone & tap_history;
                    end
                end
            end
            last_tap     = r.released_mask;
            r.held_mask  = held;
            r.hold_count = tick_cnt;
            awaited.push_back(r);
        endfunction

        function void check_result(bthd_pkg::result_t got);
            bthd_pkg::result_t want;
            if (awaited.size() == 0) begin
                $error("result %h arrived with no tick outstanding", got);
                errors++;
            end else begin
                want = awaited.pop_front();
                if (got.released_mask !== want.released_mask) begin
                    $error("released_mask: expected %h, got %h",
                           want.released_mask, got.released_mask);
                    errors++;
                end
                if (got.double_tap_mask !== want.double_tap_mask) begin
                    $error("double_tap_mask: expected %h, got %h",
                           want.double_tap_mask, got.double_tap_mask);
                    errors++;
                end
                if (got.held_mask !== want.held_mask) begin
                    $error("held_mask: expected %h, got %h", want.held_mask, got.held_mask);
                    errors++;
                end
                if (got.hold_count !== want.hold_count) begin
                    $error("hold_count: expected %0d, got %0d", want.hold_count, got.hold_count);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [39:0]                    m_axis_tdata;
    logic                           cfg_wr_en;
    logic [bthd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bthd_pkg::CFG_W-1:0]     cfg_data;

    tap_hold_tracker sb;
    bit  fast_mode    = 1'b0;
    bit  no_gaps_tx   = 1'b0;
    bit  hold_off_req = 1'b0;
    int  stuck_cycles = 0;

    button_tap_hold_detector dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == WATCHDOG_LIMIT) begin
            $error("no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        bit quiet;
        quiet = 1'b0;
        m_axis_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                quiet = !quiet;
            end
            gap = (quiet || fast_mode) ? 0 : int'($urandom_range(0, 3));
            if (hold_off_req && !fast_mode) begin
                gap = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            sb.check_result(m_axis_tdata);
        end
    end

    task automatic send_tick(input logic [7:0] raw, input logic [7:0] sw_mask);
        int gap;
        gap = (no_gaps_tx || fast_mode) ? 0 : int'($urandom_range(0, 3));
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sw_mask, raw};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_tick(raw, sw_mask);
    endtask

    // Hold one combined mask for a number of ticks, split randomly between pins and software.
    task automatic hold_buttons(input logic [7:0] mask, input int ticks);
        logic [7:0] pins;
        logic [7:0] extra;
        repeat (ticks) begin
            pins  = 8'($urandom_range(0, 255));
            extra = 8'($urandom_range(0, 255));
            send_tick(mask & pins, (mask & ~pins) | (mask & extra));
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [bthd_pkg::CFG_W-1:0] press,
                             input logic [bthd_pkg::CFG_W-1:0] hold,
                             input logic [bthd_pkg::CFG_W-1:0] window);
        cfg_wr_en <= 1'b1;
        cfg_index <= bthd_pkg::REG_MIN_PRESS;
        cfg_data  <= press;
        @(posedge aclk);
        sb.set_reg(bthd_pkg::REG_MIN_PRESS, press);
        cfg_index <= bthd_pkg::REG_MIN_HOLD;
        cfg_data  <= hold;
        @(posedge aclk);
        sb.set_reg(bthd_pkg::REG_MIN_HOLD, hold);
        cfg_index <= bthd_pkg::REG_DTAP_WIN;
        cfg_data  <= window;
        @(posedge aclk);
        sb.set_reg(bthd_pkg::REG_DTAP_WIN, window);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Aim run lengths at the thresholds so taps, holds and history expiry all occur.
    function automatic int pick_len();
        int v;
        case ($urandom_range(0, 7))
            0:       v = sb.thresholds.min_press_ticks + 1;
            1:       v = sb.thresholds.min_press_ticks + 2;
            2:       v = sb.thresholds.min_hold_ticks;
            3:       v = sb.thresholds.min_hold_ticks + 2;
            4:       v = sb.thresholds.double_tap_window + int'($urandom_range(0, 3));
            5:       v = sb.thresholds.min_press_ticks + 2 + int'($urandom_range(0, 8));
            default: v = int'($urandom_range(1, 6));
        endcase
        if (v < 1 || v > 90) begin
            v = int'($urandom_range(1, 6));
        end
        return v;
    endfunction

    task automatic run_random(input int budget);
        int         sent;
        int         n;
        int         len;
        logic [7:0] cur;
        logic [7:0] nxt;
        sent = 0;
        cur  = '0;
        hold_off_req = 1'b1;
        while (sent < budget) begin
            no_gaps_tx = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    n = int'($urandom_range(1, 4));
                    repeat (n) send_tick(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    sent += n;
                end
                1: begin
                    // tap, pause, tap again on the same buttons
                    nxt = 8'($urandom_range(1, 255));
                    repeat (2) begin
                        len = pick_len();
                        hold_buttons(nxt, len);
                        sent += len;
                        len = pick_len();
                        hold_buttons(8'h00, len);
                        sent += len;
                    end
                    cur = '0;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0, 1:    nxt = cur & 8'($urandom_range(0, 255));
                        2:       nxt = '0;
                        3:       nxt = cur | 8'($urandom_range(0, 255));
                        default: nxt = 8'($urandom_range(0, 255));
                    endcase
                    len = pick_len();
                    hold_buttons(nxt, len);
                    sent += len;
                    cur = nxt;
                end
            endcase
        end
        no_gaps_tx = 1'b0;
    endtask

    initial begin : stimulus
        sb = new();
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= bthd_pkg::REG_MIN_PRESS;
        cfg_data      <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_tick(8'h00, 8'h00);
        send_tick(8'h01, 8'h00);
        send_tick(8'h00, 8'h01);
        send_tick(8'h01, 8'h01);
        send_tick(8'h01, 8'h00);
        send_tick(8'h00, 8'h00);
        send_tick(8'h00, 8'h00);
        send_tick(8'h00, 8'h00);
        send_tick(8'h00, 8'h01);
        send_tick(8'h01, 8'h00);
        send_tick(8'h00, 8'h01);
        send_tick(8'h01, 8'h01);
        send_tick(8'h00, 8'h00);
        send_tick(8'hFF, 8'h00);
        send_tick(8'h00, 8'hFF);
        send_tick(8'hFF, 8'hFF);
        send_tick(8'hAA, 8'h55);
        send_tick(8'h55, 8'h00);
        send_tick(8'h00, 8'hAA);
        send_tick(8'h80, 8'h00);
        settle();

        // hold past the hold threshold, then release held buttons
        fast_mode = 1'b1;
        hold_buttons(8'h81, HELD_TICKS);
        send_tick(8'h01, 8'h00);
        hold_buttons(8'h01, 3);
        send_tick(8'h00, 8'h00);
        send_tick(8'h00, 8'h00);
        send_tick(8'h02, 8'h00);
        settle();
        fast_mode = 1'b0;

        configure(16'd0, 16'd3, 16'd2);
        run_random(PHASE_TICKS);
        settle();
        configure(16'd1, 16'd8, 16'd6);
        run_random(PHASE_TICKS);
        settle();
        configure(16'd0, 16'd0, 16'd0);
        run_random(PHASE_TICKS);
        settle();
        configure(16'd5, 16'd6, 16'd4);
        run_random(PHASE_TICKS);
        settle();
        configure(16'd3, 16'd20, 16'd0);
        run_random(PHASE_TICKS);
        settle();
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(PHASE_TICKS);
        settle();
        configure(16'd0, 16'hFFFF, 16'hFFFF);
        run_random(PHASE_TICKS);
        settle();
        configure(16'd10, 16'd40, 16'd25);
        run_random(PHASE_TICKS);
        settle();

        if (sb.awaited.size() != 0) begin
            $error("%0d results never arrived", sb.awaited.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
